// ===== hdl/nbdc_pkg.sv =====
// Shared types, constants and helpers for the negative-base digit converter.
// No dependencies; every other file in hdl/ imports this package.

package nbdc_pkg;

  // Default sizing handed to the top-level parameters
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 33;

  // Bits of the magnitude held by one divider cell
  localparam int CHUNK_W = 4;

  // Fixed field widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int POS_W   = 6;
  localparam int CARRY_W = 2;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd2;

  // Digit character mapping
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd65;

  // Partial remainder handed from one cell to the next lower cell
  typedef struct packed {
    logic               valid;
    logic               nonzero;
    logic [RADIX_W-1:0] rem;
  } nbdc_link_t;

  // Force the radix register into the supported range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (raw < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

  // Map a digit to '0'-'9' then 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_ALPHA + {1'b0, d - DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

// ===== hdl/nbdc_cell.sv =====
// One divider cell: holds a CHUNK_W-bit slice of the running magnitude and
// divides it by the radix, taking the remainder from the cell above.
// Depends on nbdc_pkg.

module nbdc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          load,
  input  logic [nbdc_pkg::CHUNK_W-1:0]  load_chunk,
  input  logic [nbdc_pkg::RADIX_W-1:0]  radix,
  input  nbdc_pkg::nbdc_link_t          link_in,
  output nbdc_pkg::nbdc_link_t          link_out
);
  import nbdc_pkg::*;

  logic [CHUNK_W-1:0] chunk;
  logic [CHUNK_W-1:0] quo;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W:0]   part;

  logic               valid;
  logic               nonzero;
  logic [RADIX_W-1:0] rem_out;

  // Restoring division of {remainder, chunk} by the radix, one bit per step
  always_comb begin
    rem  = link_in.rem;
    quo  = '0;
    part = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      part = {rem, chunk[i]};
      if (part >= {1'b0, radix}) begin
        quo[i] = 1'b1;
        part   = part - {1'b0, radix};
      end
      rem = part[RADIX_W-1:0];
    end
  end

  // Pass the beat marker down the row
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= link_in.valid;
    end
  end

  // Keep the quotient slice, hand the remainder and the nonzero flag on
  always_ff @(posedge clk) begin
    if (load) begin
      chunk <= load_chunk;
    end else if (adv && link_in.valid) begin
      chunk   <= quo;
      rem_out <= rem;
      nonzero <= link_in.nonzero | (quo != '0);
    end
  end

  assign link_out = '{valid: valid, nonzero: nonzero, rem: rem_out};

endmodule

// ===== hdl/negative_base_digit_converter.sv =====
// Converts a signed VALUE_WIDTH-bit integer to base -R (R = 2..36 from the
// radix register; values below 2 act as 2, above 36 as 36). Digits leave
// least significant first, one beat each, with ASCII code, position and a
// last flag; zero gives the single digit 0. The magnitude sits in a row of
// ceil(VALUE_WIDTH/4) divider cells that each divide a 4-bit slice by R per
// cycle while the output is not stalled and pass the remainder down. One
// value is converted at a time; the next is accepted once the last digit is
// formed.
// Depends on nbdc_pkg and nbdc_cell.

module negative_base_digit_converter #(
  parameter int VALUE_WIDTH = nbdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = nbdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nbdc_pkg::RADIX_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VALUE_WIDTH-1:0]       value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nbdc_pkg::DIGIT_W-1:0]        digit_value,
  output logic [nbdc_pkg::CHAR_W-1:0]         digit_char,
  output logic [nbdc_pkg::POS_W-1:0]          position,
  output logic                                last_digit
);
  import nbdc_pkg::*;

  localparam int CELLS = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W = CELLS * CHUNK_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_DIGITS - 1);

  logic [RADIX_W-1:0] radix_magnitude;
  logic [RADIX_W-1:0] radix;
  logic               running;
  logic               negative;
  logic [CARRY_W-1:0] carry;
  logic [POS_W-1:0]   count;

  logic [VALUE_WIDTH-1:0] mag;
  logic [PAD_W-1:0]       mag_pad;
  logic                   accept_in;
  logic                   adv;
  logic                   emit;

  nbdc_link_t links [CELLS+1];

  logic [RADIX_W:0]   sum;
  logic               wrap;
  logic [RADIX_W-1:0] low;
  logic [DIGIT_W-1:0] digit;
  logic               negative_next;
  logic [CARRY_W-1:0] carry_next;
  logic               last;

  assign radix     = clamp_radix(radix_magnitude);
  assign in_stall  = running;
  assign accept_in = in_valid && !running;
  assign adv       = !out_valid || !out_stall;
  assign emit      = running && links[CELLS].valid && links[0].valid;

  // Split the magnitude across the cells, most significant slice on top
  assign mag     = value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-value) : VALUE_WIDTH'(value);
  assign mag_pad = PAD_W'(mag);

  // Feed the top cell a zero remainder while a conversion runs
  assign links[CELLS] = '{valid: running, nonzero: 1'b0, rem: '0};

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    nbdc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .load       (accept_in),
      .load_chunk (mag_pad[k*CHUNK_W +: CHUNK_W]),
      .radix      (radix),
      .link_in    (links[k+1]),
      .link_out   (links[k])
    );
  end

  // Fold the pending carry into the remainder and fix the sign of the digit
  always_comb begin
    sum  = {1'b0, links[0].rem} + {{(RADIX_W + 1 - CARRY_W){1'b0}}, carry};
    wrap = sum >= {1'b0, radix};
    low  = wrap ? RADIX_W'(sum - {1'b0, radix}) : sum[RADIX_W-1:0];
    if (!negative) begin
      digit         = low;
      negative_next = 1'b1;
      carry_next    = {1'b0, wrap};
    end else if (low == '0) begin
      digit         = '0;
      negative_next = 1'b0;
      carry_next    = {1'b0, wrap};
    end else begin
      digit         = radix - low;
      negative_next = 1'b0;
      carry_next    = {1'b0, wrap} + 2'd1;
    end
    last = (!links[0].nonzero && carry_next == '0) || (count == LAST_POS);
  end

  // Control: radix register, run flag and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_magnitude <= RADIX_RESET;
      running         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        radix_magnitude <= cfg_data;
      end
      if (accept_in) begin
        running <= 1'b1;
      end else if (adv && emit && last) begin
        running <= 1'b0;
      end
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  // Digit sequencing state and output payload
  always_ff @(posedge clk) begin
    if (accept_in) begin
      negative <= value[VALUE_WIDTH-1];
      carry    <= '0;
      count    <= '0;
    end else if (adv && emit) begin
      negative <= negative_next;
      carry    <= carry_next;
      count    <= count + 1'b1;
    end
    if (adv && emit) begin
      digit_value <= digit;
      digit_char  <= digit_ascii(digit);
      position    <= count;
      last_digit  <= last;
    end
  end

endmodule

// ===== hdl/nbdc_checker.sv =====
// Port-level checks for negative_base_digit_converter, attached by bind.
// Depends on nbdc_pkg.

module nbdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [nbdc_pkg::DIGIT_W-1:0]  digit_value,
  input logic [nbdc_pkg::CHAR_W-1:0]   digit_char,
  input logic [nbdc_pkg::POS_W-1:0]    position,
  input logic                          last_digit
);
  import nbdc_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_value) && $stable(position))
    else $error("stalled output beat changed");

  // Block new values while a conversion is under way
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during a conversion");

  // Stream digits back to back with rising positions
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_digit |=>
      out_valid && position == $past(position) + 6'd1)
    else $error("digit stream broke or skipped a position");

  // Keep the character matched to the digit and the digit below RADIX_MAX
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_char == digit_ascii(digit_value) && digit_value < RADIX_MAX)
    else $error("digit character does not match digit value");

endmodule

bind negative_base_digit_converter nbdc_checker u_nbdc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .digit_value (digit_value),
  .digit_char  (digit_char),
  .position    (position),
  .last_digit  (last_digit)
);

// ===== verif/negative_base_digit_converter_tb.sv =====
// Self-checking testbench for negative_base_digit_converter: predicts every digit beat
// from a negative-base expansion model and checks each output beat in order.
// Depends on nbdc_pkg and the converter RTL; nothing else.

module negative_base_digit_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nbdc_pkg::*;

  localparam int VW         = VALUE_WIDTH_DEF;
  localparam int DIGIT_CAP  = MAX_DIGITS_DEF;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 7'd48;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 7'd65;

  // One expected or observed digit beat
  typedef struct {
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  code;
    logic [POS_W-1:0]   pos;
    logic               final_digit;
  } digit_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [RADIX_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [VW-1:0] value;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIGIT_W-1:0]   digit_value;
  logic [CHAR_W-1:0]    digit_char;
  logic [POS_W-1:0]     position;
  logic                 last_digit;

  // Shadow of the radix register and the digits still owed by the block
  logic [RADIX_W-1:0]   radix_reg;
  digit_beat_t          digits_due[$];
  int                   faults;
  int                   gap_pct;
  int                   stall_pct;
  int                   hold_off_cycles;

  negative_base_digit_converter dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("negative_base_digit_converter_tb NOT OK");
    $finish;
  end

  // Mostly short stretches, now and then a long one
  function automatic int pick_stretch();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  // Mix of full-range, small, near-limit and narrow values of either sign
  function automatic logic signed [VW-1:0] pick_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(200, 1);
      2: v = -$urandom_range(200, 1);
      3: v = 32'h7FFF_FFFF - $urandom_range(300);
      4: v = 32'h8000_0000 + $urandom_range(300);
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Expand a value into base minus R and queue one beat per digit
  function automatic void expand_negabase(input logic signed [VW-1:0] v);
    longint      n;
    longint      quo;
    longint      rem;
    longint      r;
    int          k;
    digit_beat_t d;
    r = longint'(radix_reg);
    if (r < 2) begin
      r = 2;
    end else if (r > 36) begin
      r = 36;
    end
    n = longint'(v);
    if (n == 0) begin
      d.digit = '0;
      d.code = ZERO_CODE;
      d.pos = '0;
      d.final_digit = 1'b1;
      digits_due.push_back(d);
      return;
    end
    k = 0;
    while (n != 0 && k < DIGIT_CAP) begin
      quo = n / (-r);
      rem = n % (-r);
      // pull a negative remainder back into 0..R-1
      if (rem < 0) begin
        rem += r;
        quo += 1;
      end
      n = quo;
      d.digit = DIGIT_W'(rem);
      d.code = (rem < 10) ? ZERO_CODE + CHAR_W'(rem) : ALPHA_CODE + CHAR_W'(rem - 10);
      d.pos = POS_W'(k);
      d.final_digit = (n == 0) || (k == DIGIT_CAP - 1);
      digits_due.push_back(d);
      k++;
    end
  endfunction

  // Offer one value, hold it until accepted, then queue its digits
  task automatic send_value(input logic signed [VW-1:0] v);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? pick_stretch() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      value = $urandom;
      repeat (gap) @(negedge clk);
    end
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expand_negabase(v);
  endtask

  // Drop the input and wait until every owed digit has come out
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    value = $urandom;
    while (digits_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    settle();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = r;
    @(negedge clk);
    cfg_write = 1'b0;
    radix_reg = r;
  endtask

  // Radix out of reset, zero, unit values and both signed limits
  task automatic test_reset_radix();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(-2);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
  endtask

  // Register values below two and above thirty-six clamp to the range ends
  task automatic test_radix_clamp();
    write_radix(6'd0);
    send_value(32'sh8000_0000);
    write_radix(6'd1);
    send_value(32'sh7FFF_FFFF);
    write_radix(6'd37);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    write_radix(6'd63);
    send_value(-1);
    send_value(35);
  endtask

  // Digit characters across the decimal and letter ranges
  task automatic test_digit_codes();
    write_radix(6'd36);
    send_value(35);
    send_value(-36);
    send_value(36);
    send_value(32'sh8000_0000);
    send_value(0);
    write_radix(6'd10);
    send_value(9);
    send_value(10);
    send_value(-10);
    write_radix(6'd11);
    send_value(10);
  endtask

  // Hold the output off long enough that the input stalls behind it
  task automatic test_back_pressure();
    write_radix(6'd3);
    gap_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 300;
    repeat (8) send_value(pick_value());
  endtask

  // Random values over several radix settings and idling mixes
  task automatic test_random_radix();
    logic [RADIX_W-1:0] r;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: r = 6'd2;
        1: r = 6'd36;
        2: r = 6'd7;
        default: r = RADIX_W'($urandom_range(63));
      endcase
      write_radix(r);
      gap_pct = (phase == 0) ? 0 : $urandom_range(60, 10);
      stall_pct = (phase == 0) ? 0 : $urandom_range(60, 10);
      repeat (40) send_value(pick_value());
    end
  endtask

  // Receiver: random stall stretches, plus a counted hold-off on request
  initial begin : receiver
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall = 1'b1;
        hold_off_cycles--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall = 1'b1;
        burst = pick_stretch() - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted digit beat with the oldest owed one
  always @(posedge clk) begin : digit_check
    digit_beat_t owed;
    if (!rst && out_valid && !out_stall) begin
      if (digits_due.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected digit beat: value %0d char %0d pos %0d last %0b",
                   digit_value, digit_char, position, last_digit);
        end
      end else begin
        owed = digits_due.pop_front();
        if (digit_value !== owed.digit || digit_char !== owed.code ||
            position !== owed.pos || last_digit !== owed.final_digit) begin
          faults++;
          if (faults <= 10) begin
            $display({"digit mismatch: expected value %0d char %0d pos %0d last %0b,",
                      " got value %0d char %0d pos %0d last %0b"},
                     owed.digit, owed.code, owed.pos, owed.final_digit,
                     digit_value, digit_char, position, last_digit);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    value = '0;
    radix_reg = 6'd2;
    faults = 0;
    gap_pct = 20;
    stall_pct = 20;
    hold_off_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_radix();
    test_radix_clamp();
    test_digit_codes();
    test_back_pressure();
    test_random_radix();

    // Drain, then watch for stray beats before the verdict
    settle();
    repeat (60) @(posedge clk);
    if (faults == 0) begin
      $display("negative_base_digit_converter_tb OK");
    end else begin
      $display("negative_base_digit_converter_tb NOT OK");
    end
    $finish;
  end

endmodule
